// ----- src/app_packet_deframer_macros.svh -----
// Assertion macros shared by the application packet deframer RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef APP_PACKET_DEFRAMER_MACROS_SVH
`define APP_PACKET_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define APD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("app_packet_deframer: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define APD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("app_packet_deframer: next-cycle check failed");

`endif

// ----- src/apd_pkg.sv -----
// Shared types, codes and constants of the application packet deframer.
// Depends on nothing; used by every module of the block.
package apd_pkg;

  // Default sizes handed down from the top level.
  localparam int MAX_FIELD_LEN_DEF = 255;
  localparam int QUEUE_DEPTH_DEF   = 4;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_CODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_TYPE_CODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NAME_TYPE_CODE = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [7:0] DATA_CODE_RST      = 8'd1;
  localparam logic [7:0] SIZE_TYPE_CODE_RST = 8'd0;
  localparam logic [7:0] NAME_TYPE_CODE_RST = 8'd1;

  // ASCII digit bounds; header digits are offset by the code of zero.
  localparam logic [7:0] DIGIT_ZERO = 8'd48;
  localparam logic [7:0] DIGIT_NINE = 8'd57;

  // Result kinds.
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_NAME    = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;

  // Packet status codes.
  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_BAD_CODE      = 3'd1;
  localparam logic [2:0] ST_BAD_SIZE_TYPE = 3'd2;
  localparam logic [2:0] ST_BAD_SEQ       = 3'd3;
  localparam logic [2:0] ST_TRUNCATED     = 3'd4;

  // Header parser phases.
  typedef enum logic [3:0] {
    PH_IDLE        = 4'd0,
    PH_CODE        = 4'd1,
    PH_SIZE_TYPE   = 4'd2,
    PH_SIZE_LEN    = 4'd3,
    PH_SIZE_DIGITS = 4'd4,
    PH_NAME_TYPE   = 4'd5,
    PH_NAME_LEN    = 4'd6,
    PH_NAME_BYTES  = 4'd7,
    PH_CTRL_END    = 4'd8,
    PH_SEQ         = 4'd9,
    PH_LEN_HI      = 4'd10,
    PH_LEN_LO      = 4'd11,
    PH_PAYLOAD     = 4'd12,
    PH_DATA_END    = 4'd13,
    PH_DISCARD     = 4'd14
  } phase_t;

  // One input word.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       first;
    logic       last;
    logic       expect_data;
    logic [7:0] expected_control;
    logic [7:0] expected_seq;
  } in_item_t;

  // One result word.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic [2:0]  status;
    logic        name_type_warning;
    logic [31:0] size_value;
    logic [15:0] payload_len;
    logic        end_mark;
  } out_item_t;

  // Everything one input word causes: an optional byte result and an
  // optional done result, queued between the parser and the emitter.
  typedef struct packed {
    logic        has_item;
    logic [1:0]  item_kind;
    logic [7:0]  item_byte;
    logic        has_done;
    logic [2:0]  status;
    logic        warn;
    logic [31:0] size_value;
    logic [15:0] payload_len;
  } act_t;

endpackage

// ----- src/app_packet_deframer.sv -----
// Top level of the application packet deframer: header parser, entry queue
// and result emitter. Uses apd_pkg, apd_front, apd_queue and apd_back.
//
//   Channel  Handshake        Payload             Direction
//   input    push / full      in_data  (in_item_t)  into the block
//   result   empty / pop      out_data (out_item_t) out of the block
//   config   cfg_we           cfg_index, cfg_wdata  into the block
//
// One input word is accepted per cycle while full is low; the parser updates
// its header state in that cycle and writes at most one queue entry.
// When the emitter is idle, a result passes through the queue and then the
// emitter's entry register before it shows on out_data.
// A word that ends a name or payload with a last mark yields a byte result
// and a done result; the QUEUE_DEPTH-entry queue absorbs such bursts.
// full follows the queue fill count; empty follows the emitter's register.
// Reset is synchronous and needs no clearing pass.

module app_packet_deframer #(
  parameter int MAX_FIELD_LEN = apd_pkg::MAX_FIELD_LEN_DEF,
  parameter int QUEUE_DEPTH   = apd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [apd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [apd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           push,
  output logic                           full,
  input  apd_pkg::in_item_t              in_data,
  output logic                           empty,
  input  logic                           pop,
  output apd_pkg::out_item_t             out_data
);

  logic          in_acc;
  logic          act_push, q_full, q_pop, q_empty;
  apd_pkg::act_t act, q_data;

  assign full   = q_full;
  assign in_acc = push && !q_full;

  // Header parser.
  apd_front #(
    .MAX_FIELD_LEN(MAX_FIELD_LEN)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_acc   (in_acc),
    .in_data  (in_data),
    .act_push (act_push),
    .act      (act)
  );

  // Entry queue.
  apd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (act_push),
    .wr_data(act),
    .q_full (q_full),
    .q_pop  (q_pop),
    .rd_data(q_data),
    .q_empty(q_empty)
  );

  // Result emitter.
  apd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .out_data(out_data)
  );

endmodule

// ----- src/apd_front.sv -----
// Header parser of the application packet deframer: configuration registers,
// the packet phase machine and building of queue entries. Uses apd_pkg.
`include "app_packet_deframer_macros.svh"

module apd_front #(
  parameter int MAX_FIELD_LEN = apd_pkg::MAX_FIELD_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [apd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [apd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_acc,
  input  apd_pkg::in_item_t              in_data,
  output logic                           act_push,
  output apd_pkg::act_t                  act
);

  localparam logic [7:0] MAX_LEN = 8'(MAX_FIELD_LEN);

  // Configuration registers.
  logic [7:0] data_code_r, size_type_r, name_type_r;

  // Packet state.
  apd_pkg::phase_t phase_r, phase_nxt, ph_c;
  logic [15:0] cnt_r, cnt_nxt, cnt_c, cnt_inc;
  logic [31:0] acc_r, acc_nxt, acc_c;
  logic [15:0] len_r, len_nxt, len_c, len_lo;
  logic [2:0]  err_r, err_nxt, err_c;
  logic        stop_r, stop_nxt, stop_c;
  logic        warn_r, warn_nxt, warn_c;
  logic        exp_data_r, exp_data_c;
  logic [7:0]  exp_ctrl_r, exp_ctrl_c;
  logic [7:0]  exp_seq_r, exp_seq_c;

  // Per-word helpers.
  logic [7:0]  b, d, flen;
  logic [35:0] mul;
  logic        item, done;
  logic [1:0]  item_kind;
  logic [2:0]  st;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_code_r <= apd_pkg::DATA_CODE_RST;
      size_type_r <= apd_pkg::SIZE_TYPE_CODE_RST;
      name_type_r <= apd_pkg::NAME_TYPE_CODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        apd_pkg::REG_DATA_CODE:      data_code_r <= cfg_wdata;
        apd_pkg::REG_SIZE_TYPE_CODE: size_type_r <= cfg_wdata;
        apd_pkg::REG_NAME_TYPE_CODE: name_type_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // State register; it moves only on an accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= apd_pkg::PH_IDLE;
      cnt_r      <= '0;
      acc_r      <= '0;
      len_r      <= '0;
      err_r      <= apd_pkg::ST_OK;
      stop_r     <= 1'b0;
      warn_r     <= 1'b0;
      exp_data_r <= 1'b0;
      exp_ctrl_r <= '0;
      exp_seq_r  <= '0;
    end else if (in_acc) begin
      phase_r    <= phase_nxt;
      cnt_r      <= cnt_nxt;
      acc_r      <= acc_nxt;
      len_r      <= len_nxt;
      err_r      <= err_nxt;
      stop_r     <= stop_nxt;
      warn_r     <= warn_nxt;
      exp_data_r <= exp_data_c;
      exp_ctrl_r <= exp_ctrl_c;
      exp_seq_r  <= exp_seq_c;
    end
  end

  // A first mark restarts the packet with this word as its code byte.
  always_comb begin
    if (in_data.first) begin
      ph_c       = apd_pkg::PH_CODE;
      cnt_c      = '0;
      acc_c      = '0;
      len_c      = '0;
      err_c      = apd_pkg::ST_OK;
      stop_c     = 1'b0;
      warn_c     = 1'b0;
      exp_data_c = in_data.expect_data;
      exp_ctrl_c = in_data.expected_control;
      exp_seq_c  = in_data.expected_seq;
    end else begin
      ph_c       = phase_r;
      cnt_c      = cnt_r;
      acc_c      = acc_r;
      len_c      = len_r;
      err_c      = err_r;
      stop_c     = stop_r;
      warn_c     = warn_r;
      exp_data_c = exp_data_r;
      exp_ctrl_c = exp_ctrl_r;
      exp_seq_c  = exp_seq_r;
    end
  end

  // Byte decoding: digit value, saturated field length and the next
  // decimal accumulation as acc*8 + acc*2 + digit.
  assign b       = in_data.in_byte;
  assign d       = b - apd_pkg::DIGIT_ZERO;
  assign flen    = (d > MAX_LEN) ? MAX_LEN : d;
  assign mul     = {1'b0, acc_c, 3'b000} + {3'b000, acc_c, 1'b0} + {28'd0, d};
  assign cnt_inc = cnt_c + 16'd1;
  assign len_lo  = len_c | {8'd0, b};

  // Next state and outputs of the phase machine.
  always_comb begin
    phase_nxt = ph_c;
    cnt_nxt   = cnt_c;
    acc_nxt   = acc_c;
    len_nxt   = len_c;
    err_nxt   = err_c;
    stop_nxt  = stop_c;
    warn_nxt  = warn_c;
    item      = 1'b0;
    item_kind = apd_pkg::KIND_PAYLOAD;

    unique case (ph_c)
      apd_pkg::PH_CODE: begin
        if (exp_data_c ? (d != data_code_r) : (d != exp_ctrl_c)) begin
          err_nxt   = apd_pkg::ST_BAD_CODE;
          phase_nxt = apd_pkg::PH_DISCARD;
        end else begin
          phase_nxt = exp_data_c ? apd_pkg::PH_SEQ : apd_pkg::PH_SIZE_TYPE;
        end
      end
      apd_pkg::PH_SIZE_TYPE: begin
        if (d != size_type_r) begin
          err_nxt   = apd_pkg::ST_BAD_SIZE_TYPE;
          phase_nxt = apd_pkg::PH_DISCARD;
        end else begin
          phase_nxt = apd_pkg::PH_SIZE_LEN;
        end
      end
      apd_pkg::PH_SIZE_LEN: begin
        len_nxt   = {8'd0, flen};
        cnt_nxt   = '0;
        phase_nxt = (flen == 8'd0) ? apd_pkg::PH_NAME_TYPE : apd_pkg::PH_SIZE_DIGITS;
      end
      apd_pkg::PH_SIZE_DIGITS: begin
        // Conversion stops for good at the first non-digit.
        if (!stop_c) begin
          if (b >= apd_pkg::DIGIT_ZERO && b <= apd_pkg::DIGIT_NINE) begin
            acc_nxt = (mul[35:32] != 4'd0) ? '1 : mul[31:0];
          end else begin
            stop_nxt = 1'b1;
          end
        end
        cnt_nxt = cnt_inc;
        if (cnt_inc >= len_c) begin
          phase_nxt = apd_pkg::PH_NAME_TYPE;
        end
      end
      apd_pkg::PH_NAME_TYPE: begin
        if (d != name_type_r) begin
          warn_nxt = 1'b1;
        end
        phase_nxt = apd_pkg::PH_NAME_LEN;
      end
      apd_pkg::PH_NAME_LEN: begin
        len_nxt   = {8'd0, flen};
        cnt_nxt   = '0;
        phase_nxt = (flen == 8'd0) ? apd_pkg::PH_CTRL_END : apd_pkg::PH_NAME_BYTES;
      end
      apd_pkg::PH_NAME_BYTES: begin
        item      = 1'b1;
        item_kind = apd_pkg::KIND_NAME;
        cnt_nxt   = cnt_inc;
        if (cnt_inc >= len_c) begin
          phase_nxt = apd_pkg::PH_CTRL_END;
        end
      end
      apd_pkg::PH_SEQ: begin
        if (d != exp_seq_c) begin
          err_nxt   = apd_pkg::ST_BAD_SEQ;
          phase_nxt = apd_pkg::PH_DISCARD;
        end else begin
          phase_nxt = apd_pkg::PH_LEN_HI;
        end
      end
      apd_pkg::PH_LEN_HI: begin
        len_nxt   = {b, 8'd0};
        phase_nxt = apd_pkg::PH_LEN_LO;
      end
      apd_pkg::PH_LEN_LO: begin
        len_nxt   = len_lo;
        cnt_nxt   = '0;
        phase_nxt = (len_lo == 16'd0) ? apd_pkg::PH_DATA_END : apd_pkg::PH_PAYLOAD;
      end
      apd_pkg::PH_PAYLOAD: begin
        item      = 1'b1;
        item_kind = apd_pkg::KIND_PAYLOAD;
        cnt_nxt   = cnt_inc;
        if (cnt_inc >= len_c) begin
          phase_nxt = apd_pkg::PH_DATA_END;
        end
      end
      apd_pkg::PH_IDLE, apd_pkg::PH_CTRL_END, apd_pkg::PH_DATA_END,
      apd_pkg::PH_DISCARD: ;
      default: ;
    endcase

    // Packet end: status from the error or from how far the packet got.
    done = in_data.last && (ph_c != apd_pkg::PH_IDLE);
    if (err_nxt != apd_pkg::ST_OK) begin
      st = err_nxt;
    end else if (phase_nxt == apd_pkg::PH_CTRL_END || phase_nxt == apd_pkg::PH_DATA_END) begin
      st = apd_pkg::ST_OK;
    end else begin
      st = apd_pkg::ST_TRUNCATED;
    end
    if (done) begin
      phase_nxt = apd_pkg::PH_IDLE;
    end

    act_push        = in_acc && (item || done);
    act.has_item    = item;
    act.item_kind   = item_kind;
    act.item_byte   = b;
    act.has_done    = done;
    act.status      = st;
    act.warn        = exp_data_c ? 1'b0 : warn_nxt;
    act.size_value  = exp_data_c ? 32'd0 : acc_nxt;
    act.payload_len = exp_data_c ? len_nxt : 16'd0;
  end

  // Checks.
  `APD_ASSERT_NEXT(a_last_closes_packet, clk, rst_n, in_acc && in_data.last && (ph_c != apd_pkg::PH_IDLE), phase_r == apd_pkg::PH_IDLE)
  `APD_ASSERT_IMPL(a_item_only_in_body, clk, rst_n, act_push && act.has_item, ph_c == apd_pkg::PH_NAME_BYTES || ph_c == apd_pkg::PH_PAYLOAD)

endmodule

// ----- src/apd_queue.sv -----
// Short entry queue between the header parser and the result emitter.
// Uses apd_pkg for the entry type.
`include "app_packet_deframer_macros.svh"

module apd_queue #(
  parameter int DEPTH = apd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_push,
  input  apd_pkg::act_t wr_data,
  output logic          q_full,
  input  logic          q_pop,
  output apd_pkg::act_t rd_data,
  output logic          q_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  apd_pkg::act_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign q_full  = (cnt_r == CNT_FULL);
  assign q_empty = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (q_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (q_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (q_push && !q_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (q_pop && !q_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  // Checks.
  `APD_ASSERT_NEXT(a_count_tracks_push, clk, rst_n, q_push && !q_pop, cnt_r == $past(cnt_r) + CNT_W'(1))

endmodule

// ----- src/apd_back.sv -----
// Result emitter of the application packet deframer: turns each queue entry
// into its byte result, its done result or both. Uses apd_pkg.
`include "app_packet_deframer_macros.svh"

module apd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  apd_pkg::act_t      q_data,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output apd_pkg::out_item_t out_data
);

  apd_pkg::act_t cur_r;
  logic          item_pend_r, done_pend_r;
  logic          pop_acc, last_one, free;

  // The current entry is finished when its final word is taken.
  assign empty    = !(item_pend_r || done_pend_r);
  assign pop_acc  = pop && !empty;
  assign last_one = item_pend_r ? !done_pend_r : 1'b1;
  assign free     = empty || (pop_acc && last_one);
  assign q_pop    = free && !q_empty;

  // Entry register and pending flags.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_pend_r <= 1'b0;
      done_pend_r <= 1'b0;
    end else if (q_pop) begin
      item_pend_r <= q_data.has_item;
      done_pend_r <= q_data.has_done;
    end else if (pop_acc) begin
      if (item_pend_r) begin
        item_pend_r <= 1'b0;
      end else begin
        done_pend_r <= 1'b0;
      end
    end
  end

  // Result word: the byte result goes out before the done result.
  always_comb begin
    if (item_pend_r) begin
      out_data.kind              = cur_r.item_kind;
      out_data.byte_value        = cur_r.item_byte;
      out_data.status            = apd_pkg::ST_OK;
      out_data.name_type_warning = 1'b0;
      out_data.size_value        = '0;
      out_data.payload_len       = '0;
      out_data.end_mark          = !done_pend_r;
    end else begin
      out_data.kind              = apd_pkg::KIND_DONE;
      out_data.byte_value        = '0;
      out_data.status            = cur_r.status;
      out_data.name_type_warning = cur_r.warn;
      out_data.size_value        = cur_r.size_value;
      out_data.payload_len       = cur_r.payload_len;
      out_data.end_mark          = 1'b1;
    end
  end

  // Checks.
  `APD_ASSERT_NEXT(a_load_shows_word, clk, rst_n, q_pop, !empty)

endmodule
